/* rtl/core/b64e_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the alphabet map for the Base64 stream encoder.
// No dependencies; every other file in rtl/core imports this package.
package b64e_pkg;

    // Group position codes: bytes of the current 3-byte group already taken
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // One accepted byte, turned into the characters it completes
    typedef struct packed {
        logic [3:0][7:0] chars;     // chars[0] goes out first
        logic [1:0]      last_idx;  // index of the final character
        logic            last;      // entry ends the message
    } t_b64e_entry;

    // Sextet to ASCII, standard alphabet with '+' and '/'
    function automatic logic [7:0] b64e_alpha(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;
        end else if (v < 6'd52) begin
            return w + 8'd71;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

/* rtl/core/b64e_front.sv */
`timescale 1ns / 1ps
// Front end: takes message bytes, tracks group phase and leftover bits,
// and builds one queue entry per byte. Depends on b64e_pkg.
module b64e_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output logic               o_push,
    input  logic               i_q_ready,
    output b64e_pkg::t_b64e_entry o_entry
);
    import b64e_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_left,  n_left;
    logic       w_acc;

    assign o_ready = i_q_ready;
    assign w_acc   = i_valid && i_q_ready;
    assign o_push  = w_acc;

    always_comb begin
        o_entry          = '0;
        o_entry.last     = i_last;
        o_entry.chars[2] = PAD_CHAR;
        o_entry.chars[3] = PAD_CHAR;
        n_phase          = r_phase;
        n_left           = r_left;
        unique case (r_phase)
            PH_ONE: begin
                o_entry.chars[0] = b64e_alpha({r_left[1:0], i_byte[7:4]});
                o_entry.chars[1] = b64e_alpha({i_byte[3:0], 2'b00});
                o_entry.last_idx = i_last ? 2'd2 : 2'd0;
                n_phase          = PH_TWO;
                n_left           = i_byte[3:0];
            end
            PH_TWO: begin
                o_entry.chars[0] = b64e_alpha({r_left[3:0], i_byte[7:6]});
                o_entry.chars[1] = b64e_alpha(i_byte[5:0]);
                o_entry.last_idx = 2'd1;
                n_phase          = PH_START;
                n_left           = 4'd0;
            end
            default: begin
                o_entry.chars[0] = b64e_alpha(i_byte[7:2]);
                o_entry.chars[1] = b64e_alpha({i_byte[1:0], 4'b0000});
                o_entry.last_idx = i_last ? 2'd3 : 2'd0;
                n_phase          = PH_ONE;
                n_left           = {2'b00, i_byte[1:0]};
            end
        endcase
        // end of message: restart the group
        if (i_last) begin
            n_phase = PH_START;
            n_left  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_left  <= 4'd0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_last) |=> (r_phase == PH_START && r_left == 4'd0))
        else $error("phase not restarted after last byte");
    a_phase_one_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ONE) |-> (r_left[3:2] == 2'b00))
        else $error("stray leftover bits in phase one");
    a_no_phase3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("unused group phase reached");

endmodule

/* rtl/core/b64e_queue.sv */
`timescale 1ns / 1ps
// Short register queue of encoded entries between front and back end.
// Depends on b64e_pkg.
module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_ready,
    input  b64e_pkg::t_b64e_entry i_entry,
    output logic               o_valid,
    input  logic               i_pop,
    output b64e_pkg::t_b64e_entry o_entry
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_b64e_entry      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_wr, w_rd;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_FULL) |-> !i_push)
        else $error("push into full queue");

endmodule

/* rtl/core/b64e_back.sv */
`timescale 1ns / 1ps
// Back end: unloads queue entries and sends one character per transfer
// through a registered output stage. Depends on b64e_pkg.
module b64e_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_pop,
    input  b64e_pkg::t_b64e_entry i_q_entry,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [7:0]         o_tdata,
    output logic               o_tlast
);
    import b64e_pkg::*;

    t_b64e_entry r_ent;
    logic        r_have, n_have;
    logic [1:0]  r_idx,  n_idx;
    logic        r_tvalid;
    logic [7:0]  r_tdata;
    logic        r_tlast;
    logic        w_load, w_step, w_fin;

    assign w_load = !r_tvalid || i_tready;
    assign w_step = r_have && w_load;
    assign w_fin  = w_step && (r_idx == r_ent.last_idx);
    assign o_pop  = i_q_valid && (!r_have || w_fin);

    always_comb begin
        n_have = r_have;
        n_idx  = r_idx;
        if (o_pop) begin
            n_have = 1'b1;
            n_idx  = 2'd0;
        end else if (w_fin) begin
            n_have = 1'b0;
        end else if (w_step) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_idx    <= 2'd0;
            r_tvalid <= 1'b0;
        end else begin
            r_have <= n_have;
            r_idx  <= n_idx;
            if (w_load) begin
                r_tvalid <= r_have;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_q_entry;
        end
        if (w_step) begin
            r_tdata <= r_ent.chars[r_idx];
            r_tlast <= r_ent.last && (r_idx == r_ent.last_idx);
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_idx <= r_ent.last_idx))
        else $error("character index past entry end");
    a_step_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_tvalid)
        else $error("character lost in output stage");

endmodule

/* rtl/core/base64_stream_encoder.sv */
`timescale 1ns / 1ps
// Top level of the Base64 stream encoder: front end, entry queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
//  Channel   Dir  Ports          tdata (low bit up)   tlast
//  s_axis    in   tvalid/tready  data_byte[7:0]       last byte of message
//  m_axis    out  tvalid/tready  out_char[7:0]        final character of message
//
// One character leaves per cycle from the output register while m_axis tready
// is high; a byte enters in any cycle the entry queue has room, so bytes flow
// at about 4 characters per 3 bytes.
// First character of a byte passes through the entry queue, the back end's entry register and the output register.
// Reset is synchronous and active low; it clears phase, queue and output valid.
// Output stalls fill the queue and then drop s_axis tready.
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output logic       o_m_axis_tlast
);
    import b64e_pkg::*;

    t_b64e_entry w_push_entry, w_pop_entry;
    logic        w_push, w_q_ready, w_q_valid, w_pop;

    b64e_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .o_push    (w_push),
        .i_q_ready (w_q_ready),
        .o_entry   (w_push_entry)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_entry (w_push_entry),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry)
    );

    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_pop     (w_pop),
        .i_q_entry (w_pop_entry),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule

/* verif/base64_stream_encoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_encoder: random-gap byte stream in,
// randomly stalled character stream out, characters predicted per accepted byte.
// Depends on b64e_pkg and the encoder RTL only.
module base64_stream_encoder_tb;
    import b64e_pkg::*;

    localparam int unsigned ITEM_TARGET = 460;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
    } t_b64_char;

    // Predicts the characters each byte completes and holds them until they come out
    class b64_char_scoreboard;
        string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        logic [1:0]  phase;
        logic [3:0]  spare;
        t_b64_char   chars_due[$];
        int unsigned chars_checked;

        function new();
            phase = PH_START;
            spare = 4'd0;
            chars_checked = 0;
        endfunction

        function void push_char(logic [7:0] ch);
            t_b64_char c;
            c.ch  = ch;
            c.lst = 1'b0;
            chars_due.push_back(c);
        endfunction

        function void push_sextet(logic [5:0] v);
            push_char(alphabet[v]);
        endfunction

        function void note_byte(logic [7:0] b, logic lst);
            case (phase)
                PH_ONE: begin
                    push_sextet({spare[1:0], b[7:4]});
                    if (lst) begin
                        push_sextet({b[3:0], 2'b00});
                        push_char(PAD_CHAR);
                    end else begin
                        phase = PH_TWO;
                        spare = b[3:0];
                    end
                end
                PH_TWO: begin
                    push_sextet({spare, b[7:6]});
                    push_sextet(b[5:0]);
                    phase = PH_START;
                    spare = 4'd0;
                end
                default: begin
                    push_sextet(b[7:2]);
                    if (lst) begin
                        push_sextet({b[1:0], 4'b0000});
                        push_char(PAD_CHAR);
                        push_char(PAD_CHAR);
                    end else begin
                        phase = PH_ONE;
                        spare = {2'b00, b[1:0]};
                    end
                end
            endcase
            // message end: flag its final character and start a fresh group
            if (lst) begin
                chars_due[chars_due.size() - 1].lst = 1'b1;
                phase = PH_START;
                spare = 4'd0;
            end
        endfunction

        function bit check_char(logic [7:0] ch, logic lst, output string why);
            t_b64_char want;
            why = "";
            chars_checked++;
            if (chars_due.size() == 0) begin
                why = $sformatf("char 0x%02h last=%0b with nothing pending", ch, lst);
                return 1'b1;
            end
            want = chars_due.pop_front();
            if (ch !== want.ch || lst !== want.lst) begin
                why = $sformatf("char 0x%02h last=%0b, predicted 0x%02h last=%0b",
                                ch, lst, want.ch, want.lst);
                return 1'b1;
            end
            return 1'b0;
        endfunction
    endclass

    // {last, byte} pairs: pad cases at each phase, both alphabet ends, group crossing
    localparam logic [8:0] DIRECTED [22] = '{
        9'h100,
        9'h1FF,
        9'h0FF, 9'h100,
        9'h000, 9'h1FF,
        9'h0FB, 9'h0EF, 9'h1BE,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h000, 9'h000, 9'h100,
        9'h04D, 9'h061, 9'h06E, 9'h14D,
        9'h055, 9'h0AA, 9'h10F
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;

    b64_char_scoreboard board = new();
    bit          steady = 1'b0;     // no idling on either side while set
    int unsigned errors = 0;
    int unsigned bytes_sent = 0;
    int unsigned messages_sent = 0;
    int unsigned cycles = 0;

    base64_stream_encoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),     // [7:0] data_byte
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [7:0] out_char
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d characters still pending",
                     cycles, board.chars_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string why);
        errors++;
        $display("MISMATCH at %0t: %s", $time, why);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        board.note_byte(b, lst);
        bytes_sent++;
        if (lst) begin
            messages_sent++;
        end
    endtask

    // Hold the input side quiet until every predicted character has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.chars_due.size() != 0);
    endtask

    // Output side: random stall before each transfer, then check what arrives
    initial begin
        int unsigned stall;
        string       why;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            if (board.check_char(o_m_axis_tdata, o_m_axis_tlast, why)) begin
                report_mismatch(why);
            end
        end
    end

    initial begin
        int unsigned len;
        int unsigned pick;
        logic [7:0]  b;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) begin
            send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
        end
        wait_drained();

        while (bytes_sent < ITEM_TARGET) begin
            steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                len = $urandom_range(1, 3);
            end else if (pick < 9) begin
                len = $urandom_range(1, 12);
            end else begin
                len = $urandom_range(13, 40);
            end
            for (int unsigned n = 0; n < len; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end else begin
                    b = $urandom_range(0, 255);
                end
                send_byte(b, n == len - 1);
            end
            if ($urandom_range(0, 7) == 0) begin
                wait_drained();
            end
        end

        steady = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d bytes in %0d messages, %0d characters checked",
                 bytes_sent, messages_sent, board.chars_checked);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
